// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros included by the top-level RTL file
// Concurrent assertion wrappers that compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/lge_pkg.sv =====
// ---------------------------------------------------------------------------
// Life grid engine package
// Word types, codes and constants shared by the cell rows and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package lge_pkg;

    // field widths
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 5;

    // default grid size
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
    localparam logic [CFG_W-1:0]     ROWS_RESET = 6'd5;
    localparam logic [CFG_W-1:0]     COLS_RESET = 6'd5;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // B3/S23 neighbor counts
    localparam int BIRTH_CNT   = 3;
    localparam int SURVIVE_CNT = 2;

    // input word
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             live;
    } item_in_t;

    // result word
    typedef struct packed {
        logic cell_live;
        logic any_live;
        logic border_live;
    } item_out_t;

    // command broadcast to every cell row
    typedef struct packed {
        logic step_en;
        logic load_en;
        logic load_val;
    } cell_cmd_t;

    // per-row position and addressing
    typedef struct packed {
        logic active;
        logic on_border;
        logic sel;
    } row_ctl_t;

    // per-row registered summary
    typedef struct packed {
        logic any;
        logic border;
        logic hit;
    } row_sum_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SUM,
        ST_COMB
    } state_t;

endpackage : lge_pkg

`default_nettype wire

// ===== rtl/core/lge_cell.sv =====
// ---------------------------------------------------------------------------
// Life grid cell row
// Holds one grid row, hands its visible bits to the rows above and below,
// and computes its next generation and a registered row summary.
// ---------------------------------------------------------------------------
`default_nettype none

module lge_cell #(
    parameter int COLS = lge_pkg::DEF_MAX_COLS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lge_pkg::cell_cmd_t  cmd,
    input  wire lge_pkg::row_ctl_t   rctl,
    input  wire logic [COLS-1:0]     col_mask,
    input  wire logic [COLS-1:0]     col_last,
    input  wire logic [COLS-1:0]     col_sel,
    input  wire logic [COLS-1:0]     up_row,
    input  wire logic [COLS-1:0]     dn_row,
    output logic [COLS-1:0]          row_out,
    output lge_pkg::row_sum_t        sum
);

    import lge_pkg::*;

    logic [COLS-1:0] bits_reg, bits_next;
    logic [COLS-1:0] vis;
    logic [COLS-1:0] life_next;
    logic [COLS+1:0] up_pad, mid_pad, dn_pad;
    row_sum_t        sum_reg, sum_next;

    // bits outside the used area read as dead
    assign vis     = bits_reg & col_mask & {COLS{rctl.active}};
    assign row_out = vis;

    assign up_pad  = {1'b0, up_row, 1'b0};
    assign mid_pad = {1'b0, vis, 1'b0};
    assign dn_pad  = {1'b0, dn_row, 1'b0};

    // neighbor count and rule, one column at a time
    always_comb
    begin
        logic [3:0] cnt;
        cnt = '0;
        life_next = '0;
        for (int c = 0; c < COLS; c++)
        begin
            cnt = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
                + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
                + 4'(dn_pad[c]) + 4'(dn_pad[c+1]) + 4'(dn_pad[c+2]);
            life_next[c] = col_mask[c] && rctl.active
                && ((cnt == 4'(BIRTH_CNT)) || ((cnt == 4'(SURVIVE_CNT)) && vis[c]));
        end
    end

    // row update: step, single-cell load, or hold
    always_comb
    begin
        priority if (cmd.step_en)
            bits_next = life_next;
        else if (cmd.load_en && rctl.sel)
            bits_next = (bits_reg & ~col_sel) | (col_sel & {COLS{cmd.load_val}});
        else
            bits_next = bits_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bits_reg <= '0;
        else
            bits_reg <= bits_next;
    end

    // row summary: any live, live on border, addressed cell
    always_comb
    begin
        sum_next.any    = |vis;
        sum_next.border = rctl.on_border ? (|vis) : (vis[0] | (|(vis & col_last)));
        sum_next.hit    = rctl.sel && (|(vis & col_sel));
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule : lge_cell

`default_nettype wire

// ===== rtl/core/life_grid_generation_engine_top.sv =====
// ---------------------------------------------------------------------------
// Life grid generation engine
// Game of Life (B3/S23) grid built as a column of cell rows.
// ---------------------------------------------------------------------------
// An item passes through these steps from acceptance to a loaded result register:
// it is taken in the idle state, every cell row then loads or steps in parallel,
// each row registers its summary, and the row summaries are combined into the
// result word, which waits there while the result register is stalled. A new
// word is taken once the previous one has reached the result register, so a
// stalled result does not block the next item until its own result is ready.
// Reset clears the whole grid at once. Configuration writes are always
// taken and must only happen while the engine is idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module life_grid_generation_engine_top #(
    parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // item channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire lge_pkg::item_in_t              in_data,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output lge_pkg::item_out_t                  out_data,
    // configuration channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lge_pkg::CFG_W-1:0]      cfg_data
);

    import lge_pkg::*;

    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    logic [CFG_W-1:0]    rows_cfg_reg, cols_cfg_reg;
    logic [RCW-1:0]      nr;
    logic [CCW-1:0]      nc;
    state_t              state_reg, state_next;
    item_in_t            item_reg;
    item_out_t           out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic                in_area;
    cell_cmd_t           cmd;
    logic [MAX_COLS-1:0] col_mask, col_last, col_sel;
    logic [MAX_COLS-1:0] row_vis [MAX_ROWS];
    row_sum_t            sums [MAX_ROWS];
    logic                any_all, border_all, hit_all;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ROWS)
                rows_cfg_reg <= cfg_data;
            else if (cfg_index == REG_COLS)
                cols_cfg_reg <= cfg_data;
        end
    end

    // clamp area size to 1..max
    always_comb
    begin
        priority if (rows_cfg_reg == '0)
            nr = RCW'(1);
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS))
            nr = RCW'(MAX_ROWS);
        else
            nr = RCW'(rows_cfg_reg);

        priority if (cols_cfg_reg == '0)
            nc = CCW'(1);
        else if (32'(cols_cfg_reg) > 32'(MAX_COLS))
            nc = CCW'(MAX_COLS);
        else
            nc = CCW'(cols_cfg_reg);
    end

    assign in_area = (32'(item_reg.row) < 32'(nr)) && (32'(item_reg.col) < 32'(nc));

    // column masks shared by all rows
    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_col
        assign col_mask[c] = 32'(nc) > 32'(c);
        assign col_last[c] = 32'(nc) == 32'(c) + 32'd1;
        assign col_sel[c]  = 32'(item_reg.col) == 32'(c);
    end

    // column of cell rows, each linked to its neighbors
    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_row
        row_ctl_t            rctl;
        logic [MAX_COLS-1:0] up_row, dn_row;

        assign rctl.active    = 32'(nr) > 32'(i);
        assign rctl.on_border = rctl.active
                                && ((i == 0) || (32'(nr) == 32'(i) + 32'd1));
        assign rctl.sel       = 32'(item_reg.row) == 32'(i);

        if (i == 0)
        begin : g_top
            assign up_row = '0;
        end
        else
        begin : g_up
            assign up_row = row_vis[i-1];
        end

        if (i == MAX_ROWS - 1)
        begin : g_bot
            assign dn_row = '0;
        end
        else
        begin : g_dn
            assign dn_row = row_vis[i+1];
        end

        lge_cell #(
            .COLS (MAX_COLS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .rctl     (rctl),
            .col_mask (col_mask),
            .col_last (col_last),
            .col_sel  (col_sel),
            .up_row   (up_row),
            .dn_row   (dn_row),
            .row_out  (row_vis[i]),
            .sum      (sums[i])
        );
    end

    // combine row summaries
    always_comb
    begin
        any_all    = 1'b0;
        border_all = 1'b0;
        hit_all    = 1'b0;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            any_all    = any_all | sums[i].any;
            border_all = border_all | sums[i].border;
            hit_all    = hit_all | sums[i].hit;
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                state_next = ST_SUM;
            ST_SUM:
                state_next = ST_COMB;
            ST_COMB:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        in_stall     = 1'b1;
        cmd.step_en  = 1'b0;
        cmd.load_en  = 1'b0;
        cmd.load_val = item_reg.live;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                in_stall = 1'b0;
            ST_EXEC:
            begin
                cmd.step_en = item_reg.op == OP_STEP;
                cmd.load_en = (item_reg.op == OP_LOAD) && in_area;
            end
            ST_SUM:
                in_stall = 1'b1;
            ST_COMB:
                out_load = !out_valid_reg || !out_stall;
            default:
                in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_data;
    end

    // result register
    always_comb
    begin
        out_data_next.cell_live   = hit_all
                                    && ((item_reg.op == OP_LOAD) || (item_reg.op == OP_READ));
        out_data_next.any_live    = any_all;
        out_data_next.border_live = border_all;
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `ASSERT_IMP(a_border_has_live, clk, rst_n, out_valid, !out_data.border_live || out_data.any_live)
    `ASSERT_IMP(a_result_from_comb, clk, rst_n, $rose(out_valid), $past(state_reg == ST_COMB))
    `ASSERT_NXT(a_comb_waits, clk, rst_n, state_reg == ST_COMB && out_valid && out_stall, state_reg == ST_COMB)

endmodule : life_grid_generation_engine_top

`default_nettype wire
